### hw/rtl/imuca_pkg.sv
`timescale 1ns / 1ps
package imuca_pkg;

	localparam int RATE_W   = 34;   // raw*scale + offset*256
	localparam int PROD_W   = 50;   // rate * elapsed_ms
	localparam int QUO_W    = 40;   // delta after /1000
	localparam int ACC_W    = 26;   // accel angle with offset
	localparam int MAG_W    = 48;   // |rate * elapsed_ms| < 2^48
	// x/1000 = (x * ceil(2^53/1000)) >> 53, exact for x < 2^50
	localparam int RECIP_W  = 44;
	localparam int RECIP_SH = 53;
	localparam logic [RECIP_W-1:0] RECIP = 44'd9007199254741;

	typedef enum logic [2:0] {
		REG_GOFF_X  = 3'd0,
		REG_GOFF_Y  = 3'd1,
		REG_GOFF_Z  = 3'd2,
		REG_TOFF_R  = 3'd3,
		REG_TOFF_P  = 3'd4,
		REG_BLEND_W = 3'd5,
		REG_GSCALE  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	// atan(2^-i) in Q16.16 degrees
	function automatic logic signed [31:0] atan_q16(input logic [4:0] i);
		logic signed [31:0] a;
		case (i)
			5'd0:    a = 32'sd2949120;
			5'd1:    a = 32'sd1740967;
			5'd2:    a = 32'sd919879;
			5'd3:    a = 32'sd466945;
			5'd4:    a = 32'sd234379;
			5'd5:    a = 32'sd117304;
			5'd6:    a = 32'sd58666;
			5'd7:    a = 32'sd29335;
			5'd8:    a = 32'sd14668;
			5'd9:    a = 32'sd7334;
			5'd10:   a = 32'sd3667;
			5'd11:   a = 32'sd1833;
			5'd12:   a = 32'sd917;
			5'd13:   a = 32'sd458;
			5'd14:   a = 32'sd229;
			5'd15:   a = 32'sd115;
			5'd16:   a = 32'sd57;
			5'd17:   a = 32'sd29;
			5'd18:   a = 32'sd14;
			5'd19:   a = 32'sd7;
			5'd20:   a = 32'sd4;
			5'd21:   a = 32'sd2;
			5'd22:   a = 32'sd1;
			default: a = 32'sd0;
		endcase
		return a;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sh0000_0000_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (v < -64'sh0000_0000_8000_0000)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

### hw/rtl/imuca_sqrt.sv
`timescale 1ns / 1ps
module imuca_sqrt (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [31:0]            n,
	output logic [15:0]            root,
	output imuca_pkg::unit_stat_t  stat
);

	logic [31:0] n_q;
	logic [31:0] root_q;
	logic [31:0] bit_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] trial;

	assign trial = root_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd16;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one result bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= n;
			root_q <= '0;
			bit_q  <= 32'h4000_0000;
		end else if (busy_q) begin
			if (n_q >= trial) begin
				n_q    <= n_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root      = root_q[15:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### hw/rtl/imuca_cordic.sv
`timescale 1ns / 1ps
module imuca_cordic #(
	parameter int STEPS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [16:0]     num,
	input  logic [15:0]            den,
	output logic signed [31:0]     angle,
	output imuca_pkg::unit_stat_t  stat
);

	localparam int CW = $clog2(STEPS);
	localparam int XW = 36;

	logic signed [XW-1:0] x_q, y_q, dx, dy;
	logic signed [31:0]   z_q, a;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q, done_q, zero_q;

	assign dx = y_q >>> cnt_q;
	assign dy = x_q >>> cnt_q;
	assign a  = imuca_pkg::atan_q16(5'(cnt_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// vectoring mode: drive y toward zero, accumulate the angle in z
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= XW'(den) <<< 14;
			y_q    <= XW'(num) <<< 14;
			z_q    <= '0;
			zero_q <= (num == '0);
		end else if (busy_q) begin
			if (!y_q[XW-1]) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + a;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - a;
			end
		end
	end

	assign angle     = zero_q ? 32'sd0 : z_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### hw/rtl/imuca_div.sv
`timescale 1ns / 1ps
module imuca_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [imuca_pkg::PROD_W-1:0]   dividend,
	output logic signed [imuca_pkg::QUO_W-1:0]    quo,
	output imuca_pkg::unit_stat_t                 stat
);

	localparam int MW  = imuca_pkg::MAG_W;
	localparam int QW  = imuca_pkg::QUO_W;
	localparam int HW  = imuca_pkg::MAG_W / 2;
	localparam int RH  = imuca_pkg::RECIP_W / 2;
	localparam int ACW = imuca_pkg::MAG_W + imuca_pkg::RECIP_W;

	logic [MW-1:0]    mag_q;
	logic [ACW-1:0]   acc_q;
	logic [ACW-1:0]   term;
	logic [HW-1:0]    mop;
	logic [RH-1:0]    rop;
	logic [HW+RH-1:0] part;
	logic [QW-2:0]    q;
	logic [1:0]       cnt_q;
	logic             neg_q, busy_q, done_q;
	logic [imuca_pkg::PROD_W-1:0] mag;

	assign mag  = dividend[imuca_pkg::PROD_W-1] ? -dividend : dividend;
	assign mop  = cnt_q[1] ? mag_q[MW-1:HW] : mag_q[HW-1:0];
	assign rop  = cnt_q[0] ? imuca_pkg::RECIP[imuca_pkg::RECIP_W-1:RH]
	                       : imuca_pkg::RECIP[RH-1:0];
	assign part = mop * rop;

	always_comb begin
		case (cnt_q)
			2'd0:    term = ACW'(part);
			2'd1:    term = ACW'(part) << RH;
			2'd2:    term = ACW'(part) << HW;
			default: term = ACW'(part) << (HW + RH);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// magnitude times the reciprocal, one partial product per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag[MW-1:0];
			acc_q <= '0;
			neg_q <= dividend[imuca_pkg::PROD_W-1];
		end else if (busy_q) begin
			acc_q <= acc_q + term;
		end
	end

	assign q         = acc_q[imuca_pkg::RECIP_SH +: QW-1];
	assign quo       = neg_q ? -$signed({1'b0, q}) : $signed({1'b0, q});
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### hw/rtl/imu_complementary_attitude.sv
`timescale 1ns / 1ps
// Roll/pitch complementary filter with gyro-integrated yaw. From one accept to
// the next, each IMU sample item passes through the idle state, the load and
// multiply setup states, two 16-step square roots, one CORDIC unit used twice
// (roll, then pitch), the exit from the run state, the predict, product and sum
// states, and the output state showing the result until it is taken. The three
// /1000 steps are reciprocal multiplies hidden under the square roots, so the
// square roots and the CORDIC chain set the pace.
// in_ready is high only while idle; the result item is held until taken, and
// roll_deg/pitch_deg/yaw_deg always show the filter state.
// Register writes belong in idle periods.
module imu_complementary_attitude #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [16:0]        wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] rate_x,
	input  logic signed [15:0] rate_y,
	input  logic signed [15:0] rate_z,
	input  logic [15:0]        elapsed_ms,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] roll_deg,
	output logic signed [31:0] pitch_deg,
	output logic signed [31:0] yaw_deg
);

	localparam int RW = imuca_pkg::RATE_W;
	localparam int PW = imuca_pkg::PROD_W;
	localparam int QW = imuca_pkg::QUO_W;
	localparam int AW = imuca_pkg::ACC_W;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_LOAD = 8'b0000_0010,
		S_MUL  = 8'b0000_0100,
		S_RUN  = 8'b0000_1000,
		S_PRED = 8'b0001_0000,
		S_PROD = 8'b0010_0000,
		S_SUM  = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic signed [15:0] goff_q [3];
	logic signed [15:0] toff_r_q, toff_p_q;
	logic [16:0]        blend_w_q;
	logic [15:0]        gscale_q;

	logic signed [15:0] ax_q, ay_q, az_q;
	logic signed [15:0] raw_q [3];
	logic [15:0]        ms_q;
	logic signed [RW-1:0] rate_q [3];
	logic signed [PW-1:0] prod_q [3];
	logic [31:0]        sqr_q, sqp_q;
	logic signed [AW-1:0] acc_r_q, acc_p_q;
	logic signed [31:0] pred_q [3];
	logic signed [PW:0] pa_q, pb_q, pc_q, pd_q;
	logic signed [31:0] roll_q, pitch_q, yaw_q;
	logic               cstart_q, cphase_q, acc_done_q, div_done_q, div_start_q;

	logic                 unit_start;
	logic [15:0]          root_r, root_p;
	imuca_pkg::unit_stat_t sq_r_stat, sq_p_stat, cor_stat;
	imuca_pkg::unit_stat_t div_stat [3];
	logic signed [QW-1:0] quo [3];
	logic signed [16:0]   ax_e, ay_e, cnum;
	logic [15:0]          cden;
	logic signed [31:0]   cangle;
	logic signed [17:0]   scale_s, ms_s, wc, wi;
	logic signed [PW:0]   sum_r, sum_p;

	assign unit_start = (state_q == S_MUL);
	assign ax_e       = 17'(ax_q);
	assign ay_e       = 17'(ay_q);
	assign cnum       = cphase_q ? -ax_e : ay_e;
	assign cden       = cphase_q ? root_p : root_r;
	assign scale_s    = $signed({2'b00, gscale_q});
	assign ms_s       = $signed({2'b00, ms_q});
	assign wc         = (blend_w_q > 17'd65536) ? 18'sd65536 : $signed({1'b0, blend_w_q});
	assign wi         = 18'sd65536 - wc;
	assign sum_r      = pa_q + pb_q + (PW+1)'(32768);
	assign sum_p      = pc_q + pd_q + (PW+1)'(32768);

	imuca_sqrt u_sqrt_r (
		.clk(clk), .arst_n(arst_n), .start(unit_start), .n(sqr_q),
		.root(root_r), .stat(sq_r_stat)
	);

	imuca_sqrt u_sqrt_p (
		.clk(clk), .arst_n(arst_n), .start(unit_start), .n(sqp_q),
		.root(root_p), .stat(sq_p_stat)
	);

	imuca_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cstart_q), .num(cnum), .den(cden),
		.angle(cangle), .stat(cor_stat)
	);

	// dividers start in the cycle after the products are registered
	for (genvar k = 0; k < 3; k++) begin : g_div
		imuca_div u_div (
			.clk(clk), .arst_n(arst_n), .start(div_start_q), .dividend(prod_q[k]),
			.quo(quo[k]), .stat(div_stat[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goff_q[0] <= 16'sd558;
			goff_q[1] <= -16'sd284;
			goff_q[2] <= 16'sd205;
			toff_r_q  <= -16'sd230;
			toff_p_q  <= 16'sd794;
			blend_w_q <= 17'd64225;
			gscale_q  <= 16'd500;
		end else if (wr_en) begin
			case (imuca_pkg::reg_idx_t'(wr_index))
				imuca_pkg::REG_GOFF_X:  goff_q[0] <= wr_data[15:0];
				imuca_pkg::REG_GOFF_Y:  goff_q[1] <= wr_data[15:0];
				imuca_pkg::REG_GOFF_Z:  goff_q[2] <= wr_data[15:0];
				imuca_pkg::REG_TOFF_R:  toff_r_q  <= wr_data[15:0];
				imuca_pkg::REG_TOFF_P:  toff_p_q  <= wr_data[15:0];
				imuca_pkg::REG_BLEND_W: blend_w_q <= wr_data;
				imuca_pkg::REG_GSCALE:  gscale_q  <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cstart_q    <= 1'b0;
			cphase_q    <= 1'b0;
			acc_done_q  <= 1'b0;
			div_done_q  <= 1'b0;
			div_start_q <= 1'b0;
			roll_q      <= '0;
			pitch_q     <= '0;
			yaw_q       <= '0;
		end else begin
			cstart_q    <= 1'b0;
			div_start_q <= unit_start;
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_LOAD;
				S_LOAD: state_q <= S_MUL;
				S_MUL: begin
					acc_done_q <= 1'b0;
					div_done_q <= 1'b0;
					cphase_q   <= 1'b0;
					state_q    <= S_RUN;
				end
				S_RUN: begin
					if (sq_r_stat.done && sq_p_stat.done) cstart_q <= 1'b1;
					if (cor_stat.done) begin
						if (!cphase_q) begin
							cphase_q <= 1'b1;
							cstart_q <= 1'b1;
						end else begin
							acc_done_q <= 1'b1;
						end
					end
					if (div_stat[0].done && div_stat[1].done && div_stat[2].done)
						div_done_q <= 1'b1;
					if (acc_done_q && div_done_q) state_q <= S_PRED;
				end
				S_PRED: state_q <= S_PROD;
				S_PROD: state_q <= S_SUM;
				S_SUM: begin
					roll_q  <= imuca_pkg::sat32(64'(sum_r >>> 16));
					pitch_q <= imuca_pkg::sat32(64'(sum_p >>> 16));
					yaw_q   <= pred_q[2];
					state_q <= S_OUT;
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				ax_q     <= accel_x;
				ay_q     <= accel_y;
				az_q     <= accel_z;
				raw_q[0] <= rate_x;
				raw_q[1] <= rate_y;
				raw_q[2] <= rate_z;
				ms_q     <= elapsed_ms;
			end
			S_LOAD: begin
				for (int k = 0; k < 3; k++)
					rate_q[k] <= raw_q[k] * scale_s + (RW'(goff_q[k]) <<< 8);
				sqr_q <= ax_q * ax_q + az_q * az_q;
				sqp_q <= ay_q * ay_q + az_q * az_q;
			end
			S_MUL: begin
				for (int k = 0; k < 3; k++)
					prod_q[k] <= rate_q[k] * ms_s;
			end
			S_RUN: begin
				if (cor_stat.done && !cphase_q)
					acc_r_q <= AW'(cangle) + (AW'(toff_r_q) <<< 8);
				if (cor_stat.done && cphase_q)
					acc_p_q <= AW'(cangle) + (AW'(toff_p_q) <<< 8);
			end
			S_PRED: begin
				pred_q[0] <= imuca_pkg::sat32(64'(roll_q) + 64'(quo[0]));
				pred_q[1] <= imuca_pkg::sat32(64'(pitch_q) + 64'(quo[1]));
				pred_q[2] <= imuca_pkg::sat32(64'(yaw_q) + 64'(quo[2]));
			end
			S_PROD: begin
				pa_q <= wc * pred_q[0];
				pb_q <= wi * acc_r_q;
				pc_q <= wc * pred_q[1];
				pd_q <= wi * acc_p_q;
			end
			default: ;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign roll_deg  = roll_q;
	assign pitch_deg = pitch_q;
	assign yaw_deg   = yaw_q;

endmodule

### hw/rtl/imuca_check.sv
`timescale 1ns / 1ps
module imuca_check (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] roll_deg,
	input logic signed [31:0] pitch_deg,
	input logic signed [31:0] yaw_deg
);

	// one item in flight: never ready for input while a result waits
	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("in_ready and out_valid high together");

	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (!out_valid && !in_ready))
		else $error("result or ready right after item accept");

	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> in_ready)
		else $error("not ready after result taken");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(roll_deg)
			&& $stable(pitch_deg) && $stable(yaw_deg)))
		else $error("stalled result changed");

endmodule

bind imu_complementary_attitude imuca_check u_imuca_check (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .roll_deg(roll_deg),
	.pitch_deg(pitch_deg), .yaw_deg(yaw_deg)
);

### sim/imu_complementary_attitude_tb.sv
`timescale 1ns / 1ps
module imu_complementary_attitude_tb;

	localparam int N_RANDOM   = 800;
	localparam int WDOG_LIMIT = 20000;

	typedef struct {
		logic signed [31:0] roll;
		logic signed [31:0] pitch;
		logic signed [31:0] yaw;
	} attitude_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [2:0] wr_index;
	logic [16:0] wr_data;
	logic in_valid;
	logic in_ready;
	logic signed [15:0] accel_x, accel_y, accel_z;
	logic signed [15:0] rate_x, rate_y, rate_z;
	logic [15:0] elapsed_ms;
	logic out_valid;
	logic out_ready;
	logic signed [31:0] roll_deg, pitch_deg, yaw_deg;

	imu_complementary_attitude u_top (.*);

	// predictor copy of registers and attitude
	logic signed [15:0] m_goff [3];
	logic signed [15:0] m_toff_r, m_toff_p;
	logic [16:0] m_weight;
	logic [15:0] m_scale;
	logic signed [31:0] m_roll, m_pitch, m_yaw;

	attitude_t attitude_q[$];
	int errors;
	int n_checked;
	int n_sent;
	int idle_cycles;
	bit hold_off;
	bit timed_out;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint asr64(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint root_floor(longint n);
		longint r;
		longint b;
		r = 0;
		b = 64'sd1 <<< 62;
		while (b > n)
			b = b >>> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic longint tilt_angle(longint num, longint den);
		longint x, y, z, dx, dy;
		int steps;
		x = den * 16384;
		y = num * 16384;
		z = 0;
		steps = 16;
		if (num == 0)
			return 0;
		for (int i = 0; i < steps; i++) begin
			dx = asr64(y, i);
			dy = asr64(x, i);
			if (y >= 0) begin
				x += dx;
				y -= dy;
				z += imuca_pkg::atan_q16(i[4:0]);
			end else begin
				x -= dx;
				y += dy;
				z -= imuca_pkg::atan_q16(i[4:0]);
			end
		end
		return z;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] gyro_step(logic signed [31:0] st,
			logic signed [15:0] raw, logic signed [15:0] off, longint ms);
		longint rate;
		longint delta;
		rate = longint'(raw) * longint'(m_scale) + longint'(off) * 256;
		delta = (rate * ms) / 1000;  // SV division truncates toward zero
		return clamp32(longint'(st) + delta);
	endfunction

	function automatic logic signed [31:0] fuse(logic signed [31:0] pred, longint acc);
		longint w;
		w = m_weight;
		if (w > 65536)
			w = 65536;
		return clamp32(asr64(w * longint'(pred) + (65536 - w) * acc + 32768, 16));
	endfunction

	function automatic attitude_t predict_attitude(logic signed [15:0] ax,
			logic signed [15:0] ay, logic signed [15:0] az, logic signed [15:0] gx,
			logic signed [15:0] gy, logic signed [15:0] gz, logic [15:0] ms);
		longint lx, ly, lz, acc_r, acc_p;
		logic signed [31:0] pr, pp;
		attitude_t a;
		lx = ax;
		ly = ay;
		lz = az;
		acc_r = tilt_angle(ly, root_floor(lx * lx + lz * lz)) + longint'(m_toff_r) * 256;
		acc_p = tilt_angle(-lx, root_floor(ly * ly + lz * lz)) + longint'(m_toff_p) * 256;
		pr = gyro_step(m_roll, gx, m_goff[0], longint'(ms));
		pp = gyro_step(m_pitch, gy, m_goff[1], longint'(ms));
		m_yaw = gyro_step(m_yaw, gz, m_goff[2], longint'(ms));
		m_roll = fuse(pr, acc_r);
		m_pitch = fuse(pp, acc_p);
		a.roll = m_roll;
		a.pitch = m_pitch;
		a.yaw = m_yaw;
		return a;
	endfunction

	task automatic report_mismatch(string what, logic signed [31:0] got,
			logic signed [31:0] want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic write_reg(imuca_pkg::reg_idx_t idx, logic [16:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			imuca_pkg::REG_GOFF_X:  m_goff[0] = val[15:0];
			imuca_pkg::REG_GOFF_Y:  m_goff[1] = val[15:0];
			imuca_pkg::REG_GOFF_Z:  m_goff[2] = val[15:0];
			imuca_pkg::REG_TOFF_R:  m_toff_r = val[15:0];
			imuca_pkg::REG_TOFF_P:  m_toff_p = val[15:0];
			imuca_pkg::REG_BLEND_W: m_weight = val;
			imuca_pkg::REG_GSCALE:  m_scale = val[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
			logic signed [15:0] az, logic signed [15:0] gx, logic signed [15:0] gy,
			logic signed [15:0] gz, logic [15:0] ms, bit no_gap = 0);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 10);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		repeat (gap) @(posedge clk);
		accel_x <= ax;
		accel_y <= ay;
		accel_z <= az;
		rate_x <= gx;
		rate_y <= gy;
		rate_z <= gz;
		elapsed_ms <= ms;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		in_valid <= 1'b0;
		attitude_q.push_back(predict_attitude(ax, ay, az, gx, gy, gz, ms));
		n_sent++;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (attitude_q.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rnd16();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'($urandom_range(0, 255)) - 16'sd128;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_random(bit no_gap = 0);
		logic [15:0] ms;
		ms = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
		send_sample(rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), ms, no_gap);
	endtask

	task automatic test_directed();
		send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd10);
		send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0);
		send_sample(16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd5);
		send_sample(-16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd5);
		send_sample(16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd5);
		send_sample(16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd5);
		send_sample(16'sd0, 16'sd0, 16'sd16384, 16'sd100, -16'sd100, 16'sd50, 16'd1);
		send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF);
		send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'hFFFF);
		send_sample(16'sh8000, 16'sh7FFF, 16'sd0, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'hFFFF);
		send_sample(16'sd1, -16'sd1, 16'sd0, -16'sd1, 16'sd1, 16'sd0, 16'd0);
		wait_drained();
	endtask

	task automatic test_registers();
		// gyro only, zero scale, then saturation via max scale
		write_reg(imuca_pkg::REG_BLEND_W, 17'd65536);
		write_reg(imuca_pkg::REG_GSCALE, 17'd0);
		for (int i = 0; i < 5; i++) send_random();
		wait_drained();
		write_reg(imuca_pkg::REG_BLEND_W, 17'h1FFFF);  // clamped to one
		write_reg(imuca_pkg::REG_GSCALE, 17'hFFFF);
		write_reg(imuca_pkg::REG_GOFF_X, 17'h7FFF);
		write_reg(imuca_pkg::REG_GOFF_Y, 17'h8000);
		write_reg(imuca_pkg::REG_GOFF_Z, 17'h7FFF);
		for (int i = 0; i < 6; i++)
			send_sample(16'sh7FFF, 16'sd0, 16'sd0, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'hFFFF);
		wait_drained();
		// accel only
		write_reg(imuca_pkg::REG_BLEND_W, 17'd0);
		write_reg(imuca_pkg::REG_TOFF_R, 17'h7FFF);
		write_reg(imuca_pkg::REG_TOFF_P, 17'h8000);
		for (int i = 0; i < 5; i++) send_random();
		wait_drained();
		write_reg(imuca_pkg::REG_TOFF_R, 17'h8000);
		write_reg(imuca_pkg::REG_TOFF_P, 17'h7FFF);
		write_reg(imuca_pkg::REG_GSCALE, 17'd1);
		write_reg(imuca_pkg::REG_GOFF_X, 17'h8000);
		write_reg(imuca_pkg::REG_GOFF_Y, 17'h7FFF);
		write_reg(imuca_pkg::REG_GOFF_Z, 17'h8000);
		write_reg(imuca_pkg::REG_BLEND_W, 17'd32768);
		for (int i = 0; i < 5; i++) send_random();
		wait_drained();
	endtask

	task automatic test_random();
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 200 == 0) begin
				wait_drained();
				write_reg(imuca_pkg::REG_GOFF_X, 17'($urandom));
				write_reg(imuca_pkg::REG_GOFF_Y, 17'($urandom));
				write_reg(imuca_pkg::REG_GOFF_Z, 17'($urandom));
				write_reg(imuca_pkg::REG_TOFF_R, 17'($urandom));
				write_reg(imuca_pkg::REG_TOFF_P, 17'($urandom));
				write_reg(imuca_pkg::REG_BLEND_W, 17'($urandom_range(0, 70000)));
				write_reg(imuca_pkg::REG_GSCALE, 17'($urandom_range(0, 65535)));
			end
			send_random();
		end
		wait_drained();
	endtask

	task automatic test_backpressure();
		hold_off = 1'b1;
		for (int i = 0; i < 4; i++) send_random(1);
		wait (!hold_off);
		wait_drained();
	endtask

	// receiver: a random wait after each item taken, plus a long hold-off on request
	initial begin
		int wait_n;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
				out_ready <= 1'b1;
			end else if (out_valid && out_ready) begin
				wait_n = $urandom_range(0, 10);
				if (wait_n > 0) begin
					out_ready <= 1'b0;
					repeat (wait_n) @(posedge clk);
					out_ready <= 1'b1;
				end
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		attitude_t e;
		if (arst_n && out_valid && out_ready) begin
			if (attitude_q.size() == 0) begin
				report_mismatch("unexpected item", roll_deg, 32'sd0);
			end else begin
				e = attitude_q.pop_front();
				if (roll_deg !== e.roll) report_mismatch("roll", roll_deg, e.roll);
				if (pitch_deg !== e.pitch) report_mismatch("pitch", pitch_deg, e.pitch);
				if (yaw_deg !== e.yaw) report_mismatch("yaw", yaw_deg, e.yaw);
				n_checked++;
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("Watchdog expired, %0d items outstanding", attitude_q.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		errors = 0;
		n_checked = 0;
		n_sent = 0;
		idle_cycles = 0;
		hold_off = 1'b0;
		timed_out = 1'b0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		in_valid = 1'b0;
		accel_x = '0;
		accel_y = '0;
		accel_z = '0;
		rate_x = '0;
		rate_y = '0;
		rate_z = '0;
		elapsed_ms = '0;
		m_goff[0] = 16'sd558;
		m_goff[1] = -16'sd284;
		m_goff[2] = 16'sd205;
		m_toff_r = -16'sd230;
		m_toff_p = 16'sd794;
		m_weight = 17'd64225;
		m_scale = 16'd500;
		m_roll = '0;
		m_pitch = '0;
		m_yaw = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_registers();
		test_backpressure();
		test_random();
		$display("Covered %0d samples, %0d results checked, across register extremes,",
			n_sent, n_checked);
		$display("zero/full blend weight, saturation and a long output stall.");
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
